// ===== src/eye_aspect_ratio_blink_detect_unit_assert.svh =====
// Assertion macros for the blink detector
`ifndef EYE_ASPECT_RATIO_BLINK_DETECT_UNIT_ASSERT_SVH
`define EYE_ASPECT_RATIO_BLINK_DETECT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define EARBD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EARBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EARBD_ASSERT_IMPL(lbl, ante, cons, msg)
`define EARBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/earbd_pkg.sv =====
package earbd_pkg;
    localparam int WINDOW_MAX_DEF    = 32;
    localparam int COORD_BITS_DEF    = 12;
    localparam int EAR_FRAC_BITS_DEF = 12;
    // fraction bits of each landmark distance
    localparam int DIST_FRAC         = 8;
    localparam logic [15:0] EAR_SAT       = 16'hFFFF;
    localparam logic [15:0] LIMIT_RESET   = 16'd819;
    localparam logic [5:0]  WINDOW_RESET  = 6'd8;
    // configuration register indexes
    localparam logic [1:0]  REG_LIMIT  = 2'd0;
    localparam logic [1:0]  REG_WINDOW = 2'd1;
    localparam logic [1:0]  REG_UNUSED = 2'd3;
    // landmark pair codes
    localparam logic [1:0]  PAIR_03   = 2'd0;
    localparam logic [1:0]  PAIR_15   = 2'd1;
    localparam logic [1:0]  PAIR_24   = 2'd2;
    localparam logic [1:0]  PAIR_DONE = 2'd3;
endpackage

// ===== src/eye_aspect_ratio_blink_detect_unit.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | face_present, eye_side, eye_p0..eye_p5
// out     | output    | out_valid/out_stall| face_detected, raw_ear, avg_ear,
//         |           |                    | eyes_closed, degenerate
// cfg     | input     | cfg_write          | cfg_index, cfg_data
// An eye item runs through the bit-serial squarer, the shared square root (one result
// bit a cycle) and the shared restoring divider (one quotient bit a cycle).
// A right eye item adds a history read and a history write, a second divider pass
// and the output state. A zero-width eye stops after the corner distance.
// A no-face item goes straight to the output state. One item is in work at a time.
// Reset clears holds, history pointers and sums; the history memory is not cleared.
// A stalled result holds in the output register; the next item is taken meanwhile.
`include "eye_aspect_ratio_blink_detect_unit_assert.svh"
module eye_aspect_ratio_blink_detect_unit
    import earbd_pkg::*;
#(
    parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int EAR_FRAC_BITS = EAR_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        face_present,
    input  logic        eye_side,
    input  logic [23:0] eye_p0,
    input  logic [23:0] eye_p1,
    input  logic [23:0] eye_p2,
    input  logic [23:0] eye_p3,
    input  logic [23:0] eye_p4,
    input  logic [23:0] eye_p5,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        face_detected,
    output logic [15:0] raw_ear,
    output logic [15:0] avg_ear,
    output logic        eyes_closed,
    output logic        degenerate,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int PW     = (2 * COORD_BITS > 24) ? 2 * COORD_BITS : 24;
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int RAD_W  = SQ_W + 2 * DIST_FRAC + 1;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int NUM_W  = ROOT_W + 1 + EAR_FRAC_BITS;
    localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = 16 + $clog2(WINDOW_MAX);
    localparam int DVD_W  = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int DVS_W  = (ROOT_W + 1 > FILL_W) ? ROOT_W + 1 : FILL_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);
    localparam int CW     = (FILL_W > 6) ? FILL_W : 6;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MUL, S_SQRT, S_EAR_DIV, S_EAR_END,
        S_PUSH_RD, S_PUSH_WR, S_AVG_DIV, S_DONE
    } state_t;

    state_t                  state_reg;
    logic [15:0]             limit_reg;
    logic [5:0]              window_reg;
    logic [23:0]             p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic                    face_reg, side_reg;
    logic [1:0]              pair_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [COORD_BITS-1:0]   xm_reg, ym_reg;
    logic [SQ_W-1:0]         xs_reg, ys_reg, sq_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [ROOT_W-1:0]       root_reg, d03_reg, d15_reg;
    logic [DVD_W-1:0]        dvd_reg;
    logic [DVS_W-1:0]        dvs_reg, drem_reg;
    logic [15:0]             ear_reg, raw_reg, avg_reg, left_ear_reg, rd_reg;
    logic                    deg_reg, left_deg_reg, deg_hold_reg, deg_out_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [AW-1:0]           wp_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic                    out_valid_reg, face_out_reg, closed_out_reg;
    logic [15:0]             raw_out_reg, avg_out_reg;
    logic [15:0]             hist_mem [WINDOW_MAX];

    logic [23:0]             pa, pb;
    logic [PW-1:0]           pa_ext, pb_ext;
    logic [COORD_BITS-1:0]   xa, ya, xb, yb, dx, dy;
    logic [REM_W+1:0]        srem_t, strial;
    logic [DVS_W:0]          drem_t;
    logic [ROOT_W:0]         dsum;
    logic [CW-1:0]           ws_ext;
    logic [FILL_W-1:0]       win;
    logic [AW-1:0]           wp_eff, wp_inc;
    logic [FILL_W-1:0]       fill_next;
    logic [SUM_W-1:0]        sum_next;
    logic                    out_free;

    // select the landmark pair and form absolute deltas
    always_comb
    begin
        case (pair_reg)
            PAIR_03:
            begin
                pa = p0_reg;
                pb = p3_reg;
            end
            PAIR_15:
            begin
                pa = p1_reg;
                pb = p5_reg;
            end
            default:
            begin
                pa = p2_reg;
                pb = p4_reg;
            end
        endcase
        pa_ext = PW'(pa);
        pb_ext = PW'(pb);
        xa = pa_ext[COORD_BITS-1:0];
        ya = pa_ext[2*COORD_BITS-1:COORD_BITS];
        xb = pb_ext[COORD_BITS-1:0];
        yb = pb_ext[2*COORD_BITS-1:COORD_BITS];
        dx = (xa > xb) ? xa - xb : xb - xa;
        dy = (ya > yb) ? ya - yb : yb - ya;
    end

    // one square root step and one divider step
    assign srem_t = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign strial = (REM_W + 2)'({root_reg, 2'b01});
    assign drem_t = {drem_reg, dvd_reg[DVD_W-1]};
    assign dsum   = (ROOT_W + 1)'(d15_reg) + (ROOT_W + 1)'(root_reg);

    // clamp the window and wrap the write pointer
    always_comb
    begin
        ws_ext = CW'(window_reg);
        if (window_reg == 6'd0)
            win = FILL_W'(1);
        else if (ws_ext > CW'(WINDOW_MAX))
            win = FILL_W'(WINDOW_MAX);
        else
            win = FILL_W'(ws_ext);
        wp_eff = (FILL_W'(wp_reg) >= win) ? '0 : wp_reg;
        wp_inc = ((FILL_W'(wp_reg) + FILL_W'(1)) >= win) ? '0 : wp_reg + AW'(1);
        if (fill_reg < win)
        begin
            fill_next = fill_reg + FILL_W'(1);
            sum_next  = sum_reg + SUM_W'(raw_reg);
        end
        else
        begin
            fill_next = fill_reg;
            sum_next  = sum_reg - SUM_W'(rd_reg) + SUM_W'(raw_reg);
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // history memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_PUSH_RD)
            rd_reg <= hist_mem[wp_eff];
        if (state_reg == S_PUSH_WR)
            hist_mem[wp_reg] <= raw_reg;
    end

    // sequencer, arithmetic units and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            window_reg    <= WINDOW_RESET;
            left_ear_reg  <= '0;
            left_deg_reg  <= 1'b0;
            sum_reg       <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            pair_reg      <= PAIR_03;
            cnt_reg       <= '0;
        end
        else
        begin
            // drop a taken result
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            // configuration writes
            if (cfg_write)
            begin
                if (cfg_index == REG_LIMIT)
                    limit_reg <= cfg_data;
                else if (cfg_index == REG_WINDOW)
                begin
                    window_reg <= cfg_data[5:0];
                    sum_reg    <= '0;
                    wp_reg     <= '0;
                    fill_reg   <= '0;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        p0_reg   <= eye_p0;
                        p1_reg   <= eye_p1;
                        p2_reg   <= eye_p2;
                        p3_reg   <= eye_p3;
                        p4_reg   <= eye_p4;
                        p5_reg   <= eye_p5;
                        face_reg <= face_present;
                        side_reg <= eye_side;
                        pair_reg <= PAIR_03;
                        state_reg <= face_present ? S_LOAD : S_DONE;
                    end
                end
                S_LOAD:
                begin
                    xm_reg    <= dx;
                    ym_reg    <= dy;
                    xs_reg    <= SQ_W'(dx);
                    ys_reg    <= SQ_W'(dy);
                    sq_reg    <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // add one bit of each square a cycle
                    sq_reg <= sq_reg + (xm_reg[0] ? xs_reg : '0) + (ym_reg[0] ? ys_reg : '0);
                    xs_reg <= xs_reg << 1;
                    ys_reg <= ys_reg << 1;
                    xm_reg <= xm_reg >> 1;
                    ym_reg <= ym_reg >> 1;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(COORD_BITS - 1))
                    begin
                        rad_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    // first cycle loads the radicand
                    if (cnt_reg == '0)
                    begin
                        rad_reg  <= RAD_W'(sq_reg) << (2 * DIST_FRAC);
                        rem_reg  <= '0;
                        root_reg <= '0;
                        cnt_reg  <= CNT_W'(1);
                    end
                    else
                    begin
                        rad_reg <= rad_reg << 2;
                        if (srem_t >= strial)
                        begin
                            rem_reg  <= REM_W'(srem_t - strial);
                            root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg  <= REM_W'(srem_t);
                            root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + CNT_W'(1);
                        if (cnt_reg == CNT_W'(ROOT_W))
                            state_reg <= S_EAR_END;
                    end
                end
                S_EAR_END:
                begin
                    // root_reg holds the finished distance here
                    case (pair_reg)
                        PAIR_03:
                        begin
                            d03_reg <= root_reg;
                            if (root_reg == '0)
                            begin
                                ear_reg   <= EAR_SAT;
                                deg_reg   <= 1'b1;
                                state_reg <= S_EAR_END;
                                pair_reg  <= PAIR_DONE;
                            end
                            else
                            begin
                                deg_reg   <= 1'b0;
                                pair_reg  <= PAIR_15;
                                state_reg <= S_LOAD;
                            end
                        end
                        PAIR_15:
                        begin
                            d15_reg   <= root_reg;
                            pair_reg  <= PAIR_24;
                            state_reg <= S_LOAD;
                        end
                        PAIR_24:
                        begin
                            dvd_reg   <= DVD_W'(dsum) << EAR_FRAC_BITS;
                            dvs_reg   <= DVS_W'({d03_reg, 1'b0});
                            drem_reg  <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_EAR_DIV;
                        end
                        default:
                        begin
                            // finished eye: hold a left eye, pair a right eye
                            pair_reg <= PAIR_03;
                            if (!side_reg)
                            begin
                                left_ear_reg <= ear_reg;
                                left_deg_reg <= deg_reg;
                                state_reg    <= S_IDLE;
                            end
                            else
                            begin
                                raw_reg      <= 16'((17'(left_ear_reg) + 17'(ear_reg)) >> 1);
                                deg_hold_reg <= left_deg_reg | deg_reg;
                                state_reg    <= S_PUSH_RD;
                            end
                        end
                    endcase
                end
                S_EAR_DIV, S_AVG_DIV:
                begin
                    // one restoring divider step a cycle
                    if (drem_t >= (DVS_W + 1)'(dvs_reg))
                    begin
                        drem_reg <= DVS_W'(drem_t - (DVS_W + 1)'(dvs_reg));
                        dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= DVS_W'(drem_t);
                        dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DVD_W - 1))
                    begin
                        if (state_reg == S_EAR_DIV)
                        begin
                            pair_reg  <= PAIR_DONE;
                            state_reg <= S_EAR_END;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_PUSH_RD:
                begin
                    wp_reg    <= wp_eff;
                    state_reg <= S_PUSH_WR;
                end
                S_PUSH_WR:
                begin
                    fill_reg  <= fill_next;
                    sum_reg   <= sum_next;
                    wp_reg    <= wp_inc;
                    dvd_reg   <= DVD_W'(sum_next);
                    dvs_reg   <= DVS_W'(fill_next);
                    drem_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_AVG_DIV;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        face_out_reg   <= face_reg;
                        raw_out_reg    <= face_reg ? raw_reg : '0;
                        avg_out_reg    <= face_reg ? dvd_reg[15:0] : '0;
                        closed_out_reg <= face_reg && (dvd_reg[15:0] < limit_reg);
                        deg_out_reg    <= face_reg && deg_hold_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            // saturate the eye ratio when the quotient is ready
            if (state_reg == S_EAR_DIV && cnt_reg == CNT_W'(DVD_W - 1))
            begin
                if ({dvd_reg[DVD_W-2:0], !(drem_t < (DVS_W + 1)'(dvs_reg))} >
                    DVD_W'(EAR_SAT))
                    ear_reg <= EAR_SAT;
                else
                    ear_reg <= 16'({dvd_reg[DVD_W-2:0],
                               !(drem_t < (DVS_W + 1)'(dvs_reg))});
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign face_detected = face_out_reg;
    assign raw_ear       = raw_out_reg;
    assign avg_ear       = avg_out_reg;
    assign eyes_closed   = closed_out_reg;
    assign degenerate    = deg_out_reg;

    `EARBD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state_reg != S_IDLE,
        "accepted item left the sequencer idle")
    `EARBD_ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg <= FILL_W'(WINDOW_MAX),
        "fill count beyond window maximum")
    `EARBD_ASSERT_IMPL(a_noface_zero, out_valid && !face_detected,
        raw_ear == 16'd0 && avg_ear == 16'd0 && !eyes_closed,
        "no-face result carries nonzero fields")
endmodule

// ===== verif/earbd_checker.sv =====
module earbd_checker
    import earbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        face_present,
    input  logic        eye_side,
    input  logic [23:0] eye_p0,
    input  logic [23:0] eye_p1,
    input  logic [23:0] eye_p2,
    input  logic [23:0] eye_p3,
    input  logic [23:0] eye_p4,
    input  logic [23:0] eye_p5,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        face_detected,
    input  logic [15:0] raw_ear,
    input  logic [15:0] avg_ear,
    input  logic        eyes_closed,
    input  logic        degenerate,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        face;
        logic [15:0] raw;
        logic [15:0] avg;
        logic        closed;
        logic        degen;
    } blink_status_t;

    blink_status_t status_queue[$];

    logic [15:0] limit_reg;
    logic [5:0]  window_reg;
    logic [15:0] left_ear;
    logic        left_degen;
    logic [15:0] history[WINDOW_MAX_DEF];
    logic [20:0] ear_sum;
    logic [4:0]  wr_ptr;
    logic [5:0]  fill;

    assign pending_count = status_queue.size();

    // bitwise integer square root
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] landmark_dist(input logic [23:0] a, input logic [23:0] b);
        logic [63:0] dx;
        logic [63:0] dy;
        dx = (a[11:0] > b[11:0]) ? a[11:0] - b[11:0] : b[11:0] - a[11:0];
        dy = (a[23:12] > b[23:12]) ? a[23:12] - b[23:12] : b[23:12] - a[23:12];
        return isqrt((dx * dx + dy * dy) << (2 * DIST_FRAC));
    endfunction

    // eye aspect ratio of the current request
    function automatic logic [15:0] aspect_ratio(output logic degen_o);
        logic [63:0] w;
        logic [63:0] q;
        w = landmark_dist(eye_p0, eye_p3);
        if (w == 0)
        begin
            degen_o = 1'b1;
            return EAR_SAT;
        end
        degen_o = 1'b0;
        q = ((landmark_dist(eye_p1, eye_p5) + landmark_dist(eye_p2, eye_p4))
            << EAR_FRAC_BITS_DEF) / (2 * w);
        return (q > EAR_SAT) ? EAR_SAT : q[15:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : predict
        logic [15:0] ear;
        logic        dg;
        logic [16:0] raw_sum;
        int          win;
        blink_status_t exp_s;
        blink_status_t got;
        if (!rst_n)
        begin
            limit_reg  = LIMIT_RESET;
            window_reg = WINDOW_RESET;
            left_ear   = 0;
            left_degen = 0;
            ear_sum    = 0;
            wr_ptr     = 0;
            fill       = 0;
            fail_count = 0;
            status_queue.delete();
        end
        else
        begin
            // track register writes
            if (cfg_write)
            begin
                if (cfg_index == REG_LIMIT)
                    limit_reg = cfg_data;
                else if (cfg_index == REG_WINDOW)
                begin
                    window_reg = cfg_data[5:0];
                    ear_sum = 0;
                    wr_ptr = 0;
                    fill = 0;
                end
            end
            // predict from accepted request
            if (in_valid && !in_stall)
            begin
                if (!face_present)
                    status_queue.push_back('0);
                else
                begin
                    ear = aspect_ratio(dg);
                    if (!eye_side)
                    begin
                        left_ear = ear;
                        left_degen = dg;
                    end
                    else
                    begin
                        raw_sum = left_ear + ear;
                        win = window_reg;
                        if (win == 0)
                            win = 1;
                        if (win > WINDOW_MAX_DEF)
                            win = WINDOW_MAX_DEF;
                        if (wr_ptr >= win)
                            wr_ptr = 0;
                        if (fill < win)
                            fill = fill + 1;
                        else
                            ear_sum = ear_sum - history[wr_ptr];
                        history[wr_ptr] = raw_sum[16:1];
                        ear_sum = ear_sum + raw_sum[16:1];
                        wr_ptr = wr_ptr + 1;
                        if (wr_ptr >= win)
                            wr_ptr = 0;
                        exp_s.face = 1'b1;
                        exp_s.raw = raw_sum[16:1];
                        exp_s.avg = ear_sum / fill;
                        exp_s.closed = exp_s.avg < limit_reg;
                        exp_s.degen = left_degen | dg;
                        status_queue.push_back(exp_s);
                    end
                end
            end
            // compare accepted result
            if (out_valid && !out_stall)
            begin
                got = '{face_detected, raw_ear, avg_ear, eyes_closed, degenerate};
                if (status_queue.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("mismatch: unexpected result %h", got);
                end
                else
                begin
                    exp_s = status_queue.pop_front();
                    if (got !== exp_s)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                            $display({"mismatch: exp face %b raw %h avg %h closed %b ",
                                      "degen %b, got face %b raw %h avg %h closed %b ",
                                      "degen %b"},
                                exp_s.face, exp_s.raw, exp_s.avg, exp_s.closed, exp_s.degen,
                                got.face, got.raw, got.avg, got.closed, got.degen);
                    end
                end
            end
        end
    end
endmodule

// ===== verif/tb_eye_aspect_ratio_blink_detect_unit.sv =====
module tb_eye_aspect_ratio_blink_detect_unit;
    import earbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        face_present;
    logic        eye_side;
    logic [23:0] eye_p0, eye_p1, eye_p2, eye_p3, eye_p4, eye_p5;
    logic        out_valid;
    logic        out_stall;
    logic        face_detected;
    logic [15:0] raw_ear;
    logic [15:0] avg_ear;
    logic        eyes_closed;
    logic        degenerate;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_recv;
    bit          sending_done;
    int          quiet_cycles;

    localparam int QUIET_LIMIT = 20000;

    eye_aspect_ratio_blink_detect_unit dut (.*);
    earbd_checker checker_i (.*);

    initial
    begin
        clk = 0;
    end

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // receiver stall
    always @(posedge clk)
    begin
        if (hold_recv)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT && (!sending_done || pending_count != 0))
        begin
            $display("FAIL eye_aspect_ratio_blink_detect_unit");
            $finish;
        end
    end

    // random landmark within a given coordinate spread around a center
    function automatic logic [23:0] near_point(input logic [23:0] c, input int spread);
        logic [11:0] x;
        logic [11:0] y;
        x = 12'(int'(c[11:0]) + int'($urandom_range(2 * spread)) - spread);
        y = 12'(int'(c[23:12]) + int'($urandom_range(2 * spread)) - spread);
        return {y, x};
    endfunction

    // offer one request; valid stays up after acceptance unless idling follows
    task automatic send_eye(input logic fp, input logic side,
                            input logic [23:0] a0, input logic [23:0] a1,
                            input logic [23:0] a2, input logic [23:0] a3,
                            input logic [23:0] a4, input logic [23:0] a5);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        face_present <= fp;
        eye_side <= side;
        eye_p0 <= a0;
        eye_p1 <= a1;
        eye_p2 <= a2;
        eye_p3 <= a3;
        eye_p4 <= a4;
        eye_p5 <= a5;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drop valid after the last accepted request
    task automatic stop_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_eye(input logic side);
        logic [23:0] c;
        int sp;
        c = 24'($urandom);
        sp = ($urandom_range(3) == 0) ? 2047 : int'($urandom_range(1, 60));
        send_eye(1'b1, side, near_point(c, sp), near_point(c, sp), near_point(c, sp),
                 near_point(c, sp), near_point(c, sp), near_point(c, sp));
    endtask

    task automatic drain();
        stop_input();
        while (pending_count != 0)
            @(posedge clk);
        repeat (400)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int k;
        int r;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                send_random_eye(1'b0);
                send_random_eye(1'b1);
                k++;
            end
            else if (r < 88)
                send_eye(1'b0, 1'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                         24'($urandom), 24'($urandom), 24'($urandom));
            else
                send_random_eye(1'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        face_present = 0;
        eye_side = 0;
        {eye_p0, eye_p1, eye_p2, eye_p3, eye_p4, eye_p5} = '0;
        cfg_write = 0;
        cfg_index = REG_LIMIT;
        cfg_data = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_recv = 0;
        sending_done = 0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: right without left, extremes, zero width, no face
        send_eye(1'b1, 1'b1, 24'h000000, 24'h000000, 24'h000000,
                 24'h000001, 24'h000000, 24'h000000);
        send_eye(1'b1, 1'b0, 24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                 24'h000001, 24'h000000, 24'h000000);
        send_eye(1'b1, 1'b1, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
                 24'h000000, 24'h000000, 24'hFFFFFF);
        send_eye(1'b1, 1'b0, 24'h123456, 24'h000000, 24'h000000,
                 24'h123456, 24'hFFFFFF, 24'hFFFFFF);
        send_eye(1'b1, 1'b1, 24'h000000, 24'h001002, 24'h002003,
                 24'h000FFF, 24'h000002, 24'h000003);
        send_eye(1'b0, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_eye(1'b1, 1'b0, 24'h010010, 24'h014012, 24'h014016,
                 24'h010020, 24'h00C016, 24'h00C012);
        send_eye(1'b1, 1'b1, 24'h010010, 24'h011012, 24'h011016,
                 24'h010020, 24'h00F016, 24'h00F012);
        send_eye(1'b1, 1'b1, 24'hFFF000, 24'h000FFF, 24'hFFFFFF,
                 24'h000000, 24'h000FFF, 24'hFFF000);
        drain();

        // window and limit extremes
        write_reg(REG_WINDOW, 16'd1);
        write_reg(REG_LIMIT, 16'hFFFF);
        send_idle_pct = 14;
        recv_idle_pct = 76;
        random_phase(300);
        drain();
        write_reg(REG_WINDOW, 16'd32);
        write_reg(REG_LIMIT, 16'd0);
        write_reg(REG_UNUSED, 16'h1234);
        send_idle_pct = 76;
        recv_idle_pct = 14;
        random_phase(300);

        // sender pause until all results have arrived
        drain();
        write_reg(REG_WINDOW, 16'hFFC0);
        write_reg(REG_LIMIT, 16'd3000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(300);
        drain();
        write_reg(REG_WINDOW, 16'd63);
        random_phase(200);
        drain();
        write_reg(REG_WINDOW, 16'd5);
        write_reg(REG_LIMIT, 16'd2048);

        // long receiver hold while requests keep coming
        hold_recv = 1;
        fork
            begin
                repeat (3000)
                    @(posedge clk);
                hold_recv = 0;
            end
            begin
                random_phase(40);
                stop_input();
            end
        join
        recv_idle_pct = 30;
        send_idle_pct = 30;
        random_phase(760);

        sending_done = 1;
        drain();
        if (fail_count == 0)
            $display("PASS eye_aspect_ratio_blink_detect_unit");
        else
            $display("FAIL eye_aspect_ratio_blink_detect_unit");
        $finish;
    end
endmodule
